/* hdl/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 hasher.
`default_nettype none
package sha256_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_LOAD,
    ST_ROUNDS,
    ST_UPDATE,
    ST_EMIT
  } ctrl_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load;       // working vars from chain
    logic       round;      // run one round
    logic       update;     // chain += working vars
    logic       init_chain; // chain back to initial values
  } dp_cmd_t;

  localparam logic [31:0] InitChain [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* hdl/sha256_datapath.sv */
// Block buffer, message schedule, round logic and chaining words.
`default_nettype none
module sha256_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sha256_pkg::dp_cmd_t cmd,
  input  wire logic                wr_en,    // write one block byte
  input  wire logic [5:0]          wr_addr,
  input  wire logic [7:0]          wr_data,
  input  wire logic [5:0]          round_idx,
  input  wire logic [2:0]          rd_word,
  output logic [31:0]              chain_word
);

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] chain [8];
  logic [31:0] w_cur, s0, s1, w_new, t1, t2;

  // one round: schedule word and compression
  always_comb begin
    s0 = sha256_pkg::ror(w[1], 7) ^ sha256_pkg::ror(w[1], 18) ^ (w[1] >> 3);
    s1 = sha256_pkg::ror(w[14], 17) ^ sha256_pkg::ror(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    w_cur = w[0];
    t1 = v[7] + (sha256_pkg::ror(v[4], 6) ^ sha256_pkg::ror(v[4], 11)
         ^ sha256_pkg::ror(v[4], 25)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + sha256_pkg::RoundK[round_idx] + w_cur;
    t2 = (sha256_pkg::ror(v[0], 2) ^ sha256_pkg::ror(v[0], 13)
         ^ sha256_pkg::ror(v[0], 22)) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // schedule as a 16-word shift line: block bytes land in place while collecting
  // (byte 0 is the top byte of w[0]); during rounds w[0] is the current word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      w[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (rst || cmd.init_chain) begin
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::InitChain[i];
    end else if (cmd.update) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
    end
  end

  assign chain_word = chain[rd_word];

endmodule
`default_nettype wire

/* hdl/sha256_controller.sv */
// Controller: byte intake, padding, round sequencing and digest output.
`default_nettype none
module sha256_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_present,
  input  wire logic                 in_end,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_word,
  output sha256_pkg::dp_cmd_t       cmd,
  output logic                      wr_en,
  output logic [5:0]                wr_addr,
  output logic [7:0]                wr_data,
  output logic [5:0]                round_idx
);

  sha256_pkg::ctrl_state_t state, state_next;
  logic [5:0]  fill, fill_next;       // bytes held, or padding position
  logic [63:0] message_bits, message_bits_next;
  logic [5:0]  round_count, round_count_next;
  logic [2:0]  word, word_next;
  logic        padding, padding_next; // in padding pass
  logic        marker, marker_next;   // 0x80 marker still to be written
  logic        len_here, len_here_next; // length goes at the end of this padding block
  logic        finishing, finishing_next; // last block after padding
  logic        len_in_block;          // length lands in the current padding block
  logic [2:0]  len_byte;              // byte of the bit count, from the low end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_COLLECT;
      fill <= '0;
      message_bits <= '0;
      round_count <= '0;
      word <= '0;
      padding <= 1'b0;
      marker <= 1'b0;
      len_here <= 1'b0;
      finishing <= 1'b0;
    end else begin
      state <= state_next;
      fill <= fill_next;
      message_bits <= message_bits_next;
      round_count <= round_count_next;
      word <= word_next;
      padding <= padding_next;
      marker <= marker_next;
      len_here <= len_here_next;
      finishing <= finishing_next;
    end
  end

  // length fits in this block when the marker sits before byte 56
  assign len_in_block = marker ? (fill < 6'd56) : len_here;
  assign len_byte = ~fill[2:0];

  always_comb begin
    state_next = state;
    fill_next = fill;
    message_bits_next = message_bits;
    round_count_next = round_count;
    word_next = word;
    padding_next = padding;
    marker_next = marker;
    len_here_next = len_here;
    finishing_next = finishing;
    cmd = '0;
    wr_en = 1'b0;
    wr_addr = fill;
    wr_data = in_byte;
    in_ready = 1'b0;
    out_valid = 1'b0;
    round_idx = round_count;
    case (state)
      sha256_pkg::ST_COLLECT: begin
        if (!padding) begin
          in_ready = 1'b1;
          if (in_valid && in_present) begin
            wr_en = 1'b1;
            message_bits_next = message_bits + 64'd8;
            fill_next = fill + 6'd1;
            if (fill == 6'd63) state_next = sha256_pkg::ST_LOAD;
          end
          // end mark: pad after any byte in this item
          if (in_valid && in_end) begin
            padding_next = 1'b1;
            marker_next = 1'b1;
          end
        end else begin
          // padding pass, one byte a cycle
          wr_en = 1'b1;
          if (marker) begin
            wr_data = 8'h80;
            marker_next = 1'b0;
            len_here_next = (fill < 6'd56);
          end else if (len_here && fill >= 6'd56) begin
            wr_data = message_bits[8*len_byte +: 8];
          end else begin
            wr_data = 8'h00;
          end
          fill_next = fill + 6'd1;
          if (fill == 6'd63) begin
            state_next = sha256_pkg::ST_LOAD;
            finishing_next = len_in_block;
            // a further padding block always carries the length
            len_here_next = 1'b1;
          end
        end
      end
      sha256_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        round_count_next = '0;
        state_next = sha256_pkg::ST_ROUNDS;
      end
      sha256_pkg::ST_ROUNDS: begin
        cmd.round = 1'b1;
        round_count_next = round_count + 6'd1;
        if (round_count == 6'(sha256_pkg::Rounds - 1)) state_next = sha256_pkg::ST_UPDATE;
      end
      sha256_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        if (finishing) begin
          state_next = sha256_pkg::ST_EMIT;
          word_next = '0;
        end else begin
          state_next = sha256_pkg::ST_COLLECT;
        end
      end
      sha256_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          word_next = word + 3'd1;
          if (word == 3'd7) begin
            cmd.init_chain = 1'b1;
            state_next = sha256_pkg::ST_COLLECT;
            fill_next = '0;
            message_bits_next = '0;
            padding_next = 1'b0;
            marker_next = 1'b0;
            len_here_next = 1'b0;
            finishing_next = 1'b0;
            word_next = '0;
          end
        end
      end
      default: state_next = sha256_pkg::ST_COLLECT;
    endcase
  end

  assign out_word = word;

endmodule
`default_nettype wire

/* hdl/sha256_message_hasher.sv */
// Top level of the streaming SHA-256 hasher.
//
// channel | dir | fields (tdata / tuser / tlast)
// s_axis  | in  | tdata[7:0] msg_byte; tuser byte_present; tlast msg_end
// m_axis  | out | tdata[31:0] digest_word; tuser word_number; tlast digest_last
//
// A byte item is taken while collecting; a full block then goes through load, 64
// rounds and chain update on the single shared round unit. An end item pads
// byte-serially, compresses one or two blocks, then streams eight digest words.
// Input is held off during all of it.
// rst is synchronous; m_axis_tready stalls the digest words only.
`default_nettype none
module sha256_message_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  wire logic        s_axis_tuser,   // byte_present
  input  wire logic        s_axis_tlast,   // msg_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_number
  output logic             m_axis_tlast    // digest_last
);

  sha256_pkg::dp_cmd_t cmd;
  logic       wr_en;
  logic [5:0] wr_addr;
  logic [7:0] wr_data;
  logic [5:0] round_idx;
  logic [2:0] out_word;

  sha256_controller u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_present(s_axis_tuser), .in_end(s_axis_tlast),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_word,
    .cmd, .wr_en, .wr_addr, .wr_data, .round_idx
  );

  sha256_datapath u_dp (
    .clk, .rst, .cmd, .wr_en, .wr_addr, .wr_data, .round_idx,
    .rd_word(out_word), .chain_word(m_axis_tdata)
  );

  assign m_axis_tuser = out_word;
  assign m_axis_tlast = (out_word == 3'd7);

endmodule
`default_nettype wire

/* sim/sha256_digest_checker.sv */
// Digest checker for the SHA-256 hasher: tracks message state and compares digest words.
`default_nettype none
module sha256_digest_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,
  input  wire logic [2:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  output int               fail_count,
  output int               words_pending,
  output int               digests_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic [31:0]  hash_state [8];
  logic [7:0]   pending_bytes [64];
  int           fill_level;
  logic [63:0]  bit_length;
  digest_item_t digest_queue [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of pending_bytes into hash_state
  task automatic compress_pending();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {pending_bytes[4*i], pending_bytes[4*i+1], pending_bytes[4*i+2],
              pending_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::InitChain[i];
    fill_level = 0;
    bit_length = '0;
  endtask

  // update the prediction for one accepted input item
  task automatic absorb_item(logic [7:0] b, logic present, logic fin);
    digest_item_t d;
    if (present) begin
      pending_bytes[fill_level] = b;
      fill_level++;
      bit_length += 64'd8;
      if (fill_level == 64) begin
        compress_pending();
        fill_level = 0;
      end
    end
    if (fin) begin
      pending_bytes[fill_level] = 8'h80;
      for (int i = fill_level + 1; i < 64; i++) pending_bytes[i] = '0;
      if (fill_level >= 56) begin
        compress_pending();
        for (int i = 0; i < 56; i++) pending_bytes[i] = '0;
      end
      for (int i = 0; i < 8; i++) pending_bytes[56+i] = bit_length[63-8*i -: 8];
      compress_pending();
      for (int i = 0; i < 8; i++) begin
        d.word = hash_state[i];
        d.index = 3'(i);
        d.last = (i == 7);
        digest_queue.push_back(d);
      end
      restart_message();
    end
  endtask

  always @(posedge clk) begin
    digest_item_t exp_item;
    if (rst) begin
      restart_message();
      digest_queue.delete();
      fail_count <= 0;
      digests_seen <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        absorb_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest word: expected none, got %h idx %0d last %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_count <= fail_count + 1;
        end else begin
          exp_item = digest_queue.pop_front();
          if (m_axis_tdata !== exp_item.word || m_axis_tuser !== exp_item.index ||
              m_axis_tlast !== exp_item.last) begin
            $display("%0t: digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                     $time, exp_item.word, exp_item.index, exp_item.last,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fail_count <= fail_count + 1;
          end
          if (exp_item.last) digests_seen <= digests_seen + 1;
        end
      end
    end
    words_pending = digest_queue.size();
  end

  initial begin
    fail_count = 0;
    digests_seen = 0;
    words_pending = 0;
  end
endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench top: drives byte streams into the SHA-256 hasher and gives the verdict.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          words_pending;
  int          digests_seen;

  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int          items_sent;
  int          idle_cycles;

  sha256_message_hasher i_dut (.*);

  sha256_digest_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (rst || hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // offer one item and wait until it is taken
  task automatic send_item(logic [7:0] b, logic present, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = present;
    s_axis_tlast  = fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // a message of n random bytes; end carried by the last byte or by an empty item
  task automatic send_message(int n, bit end_alone);
    for (int i = 0; i < n; i++)
      send_item(8'($urandom), 1'b1, !end_alone && (i == n - 1));
    if (end_alone || n == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    while (words_pending != 0) @(negedge clk);
  endtask

  task automatic long_holdoff();
    int hold_cycles;
    hold_cycles = 300;
    hold_off = 1'b1;
    repeat (hold_cycles) @(negedge clk);
    hold_off = 1'b0;
  endtask

  initial begin
    int done;
    rst = 1'b1;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    idle_cycles = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: empty message, an idle item, byte extremes, byte with end
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b1, 1'b1);
    drain();

    // pressure: receiver holds off while the sender keeps offering items;
    // the long message fills a whole block and puts 56 bytes in the next one
    fork
      long_holdoff();
      begin
        send_message(2, 1'b1);
        send_message(120, 1'b0);
      end
    join
    drain();

    // random phases with different idling mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      done = 0;
      while (done < 3) begin
        if ($urandom_range(9) == 0) begin
          send_item(8'($urandom), 1'b0, 1'b0);
          done += 1;
        end else begin
          int n;
          n = $urandom_range(3);
          send_message(n, $urandom_range(1));
          done += (n == 0) ? 1 : n;
        end
      end
      drain();
    end

    drain();
    repeat (200) @(negedge clk);
    $display("tb: %0d items sent, %0d digests checked over 4 idling phases", items_sent,
             digests_seen);
    $display("tb: covered empty messages, byte-and-end items and padding boundaries");
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
